// ----- src/sfd_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the sensor frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned GROUP_W   = 3;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

  localparam int unsigned FRAME_LEN  = 18;
  localparam int unsigned GROUP_LEN  = 3;
  localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(FRAME_LEN / GROUP_LEN - 1);
  localparam logic [GROUP_W-1:0] CO2_END    = 3'd2;
  localparam logic [GROUP_W-1:0] TEMP_END   = 3'd4;

  typedef enum logic [1:0] {
    PH_DATA_HI = 2'd0,
    PH_DATA_LO = 2'd1,
    PH_CHECK   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
  } sfd_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] co2_raw;
    logic [WORD_W-1:0] temperature_raw;
    logic [WORD_W-1:0] humidity_raw;
    logic              crc_error;
  } sfd_result_t;

  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if ((v & CRC_TOP) != '0) begin
        v = (v << 1) ^ CRC_POLY;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

endpackage

// ----- src/sfd_in_reg.sv -----
// Input register that holds one byte request until the frame logic takes it.
`timescale 1ns / 1ps

module sfd_in_reg
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sfd_item_t  in_item,
  input  logic       advance,
  output logic       item_valid,
  output sfd_item_t  item
);

  logic      valid_r;
  logic      valid_nxt;
  sfd_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- src/sfd_frame_unit.sv -----
// Frame position tracking, CRC check, big-endian packing: one byte per cycle on advance.
`timescale 1ns / 1ps

module sfd_frame_unit
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sfd_item_t   item,
  input  logic        advance,
  output logic        last,
  output sfd_result_t result
);

  phase_t            phase_r, phase_nxt;
  logic [GROUP_W-1:0] group_r, group_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [WORD_W-1:0] co2_r, co2_nxt;
  logic [WORD_W-1:0] temp_r, temp_nxt;
  logic [WORD_W-1:0] hum_r, hum_nxt;
  logic              err_r, err_nxt;

  logic              restart;
  phase_t            phase_c;
  logic [GROUP_W-1:0] group_c;
  logic [BYTE_W-1:0] crc_c;
  logic [WORD_W-1:0] co2_c, temp_c, hum_c;
  logic              err_c;

  always_comb begin
    restart = item.frame_start || (group_r > LAST_GROUP) || (phase_r > PH_CHECK);
    phase_c = restart ? PH_DATA_HI : phase_r;
    group_c = restart ? '0 : group_r;
    crc_c   = restart ? CRC_INIT : crc_r;
    co2_c   = restart ? '0 : co2_r;
    temp_c  = restart ? '0 : temp_r;
    hum_c   = restart ? '0 : hum_r;
    err_c   = restart ? 1'b0 : err_r;

    phase_nxt = phase_c;
    group_nxt = group_c;
    crc_nxt   = crc_c;
    co2_nxt   = co2_c;
    temp_nxt  = temp_c;
    hum_nxt   = hum_c;
    err_nxt   = err_c;
    last      = 1'b0;

    unique case (phase_c)
      PH_DATA_HI, PH_DATA_LO: begin
        crc_nxt   = crc8_byte(crc_c, item.data_byte);
        phase_nxt = (phase_c == PH_DATA_HI) ? PH_DATA_LO : PH_CHECK;
        if (group_c < CO2_END) begin
          co2_nxt = {co2_c[WORD_W-BYTE_W-1:0], item.data_byte};
        end else if (group_c < TEMP_END) begin
          temp_nxt = {temp_c[WORD_W-BYTE_W-1:0], item.data_byte};
        end else begin
          hum_nxt = {hum_c[WORD_W-BYTE_W-1:0], item.data_byte};
        end
      end
      default: begin
        if (crc_c != item.data_byte) begin
          err_nxt = 1'b1;
        end
        crc_nxt   = CRC_INIT;
        phase_nxt = PH_DATA_HI;
        group_nxt = group_c + 1'b1;
        last      = (group_c == LAST_GROUP);
      end
    endcase

    result.co2_raw         = co2_c;
    result.temperature_raw = temp_c;
    result.humidity_raw    = hum_c;
    result.crc_error       = err_nxt;

    if (last) begin
      group_nxt = '0;
      co2_nxt   = '0;
      temp_nxt  = '0;
      hum_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DATA_HI;
      group_r <= '0;
      crc_r   <= CRC_INIT;
      co2_r   <= '0;
      temp_r  <= '0;
      hum_r   <= '0;
      err_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      group_r <= group_nxt;
      crc_r   <= crc_nxt;
      co2_r   <= co2_nxt;
      temp_r  <= temp_nxt;
      hum_r   <= hum_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- src/sensor_frame_crc8_deframer_core.sv -----
// Top level of the sensor frame deframer: input register, frame logic and result register.
`timescale 1ns / 1ps
// The block takes an 18-byte measurement frame one byte per request on the in_ channel.
// The frame is six groups of two data bytes and one CRC-8 byte (polynomial 0x31, start
// value 0xFF). Data bytes are packed big-endian into the CO2, temperature and humidity
// words. After the eighteenth byte one request appears on the out_ channel with the three
// words and a flag that is set if any group check failed; then the next frame begins.
// Setting in_frame_start marks a byte as the first of a frame and drops any partial frame.
// Throughput is one byte per cycle unless a final byte waits on a stalled result: the CRC
// update, check and packing are combinational between the input register and the state
// and result registers. A final byte passes the input register, then the result register.
// After reset, no request is held, the position is the start of a frame and out_valid is
// low. When the receiver stalls, the result stays in the output register; further bytes
// are still taken until the final byte of the next frame, which waits in the input
// register, and only then does in_ready drop.
module sensor_frame_crc8_deframer_core
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_frame_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_co2_raw,
  output logic [WORD_W-1:0] out_temperature_raw,
  output logic [WORD_W-1:0] out_humidity_raw,
  output logic              out_crc_error
);

  sfd_item_t   in_item;
  sfd_item_t   item;
  logic        item_valid;
  logic        advance;
  logic        last;
  logic        out_free;
  sfd_result_t result;
  sfd_result_t result_r;
  logic        out_valid_r, out_valid_nxt;

  assign in_item.data_byte   = in_data_byte;
  assign in_item.frame_start = in_frame_start;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = item_valid && (!last || out_free);

  sfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sfd_frame_unit u_frame_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .last    (last),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last) begin
      result_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_co2_raw         = result_r.co2_raw;
  assign out_temperature_raw = result_r.temperature_raw;
  assign out_humidity_raw    = result_r.humidity_raw;
  assign out_crc_error       = result_r.crc_error;

endmodule

// ----- src/sfd_checker.sv -----
// Port-level checker for the sensor frame deframer, bound to the top level.
`timescale 1ns / 1ps

module sfd_checker
  import sfd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [BYTE_W-1:0] in_data_byte,
  input logic              in_frame_start,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_co2_raw,
  input logic [WORD_W-1:0] out_temperature_raw,
  input logic [WORD_W-1:0] out_humidity_raw,
  input logic              out_crc_error
);

  // A waiting byte request must hold still until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) && $stable(in_frame_start))
    else $error("byte request changed or vanished while waiting");

  // A stalled result must hold still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_co2_raw)
      && $stable(out_temperature_raw) && $stable(out_humidity_raw)
      && $stable(out_crc_error))
    else $error("result changed or vanished while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request present after reset");

  // With no result waiting, the block must always take a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // A new result must follow an accepted byte, with the input and result registers between.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an accepted byte two cycles earlier");

endmodule

bind sensor_frame_crc8_deframer_core sfd_checker u_sfd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_data_byte        (in_data_byte),
  .in_frame_start      (in_frame_start),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_co2_raw         (out_co2_raw),
  .out_temperature_raw (out_temperature_raw),
  .out_humidity_raw    (out_humidity_raw),
  .out_crc_error       (out_crc_error)
);

// ----- tb/sv/sensor_frame_crc8_deframer_core_tb.sv -----
// Self-checking testbench for the sensor frame deframer with a frame scoreboard class.
`timescale 1ns / 1ps

module sensor_frame_crc8_deframer_core_tb;
  import sfd_pkg::*;

  localparam int PHASES         = 5;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 206;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SEND_IDLE[PHASES]  = '{0, 50, 0, 16, 0};
  localparam int RECV_STALL[PHASES] = '{0, 0, 50, 16, 0};

  class frame_predictor;
    logic [4:0]        byte_pos;
    logic [BYTE_W-1:0] crc_acc;
    logic [WORD_W-1:0] co2_word;
    logic [WORD_W-1:0] temp_word;
    logic [WORD_W-1:0] hum_word;
    logic              err_seen;
    sfd_result_t       expected_frames[$];
    int unsigned       mismatches;
    int unsigned       frames_checked;
    int unsigned       frames_corrupt;
    int unsigned       frames_abandoned;

    function new();
      restart();
    endfunction

    function void restart();
      byte_pos  = '0;
      crc_acc   = CRC_INIT;
      co2_word  = '0;
      temp_word = '0;
      hum_word  = '0;
      err_seen  = 1'b0;
    endfunction

    function logic [BYTE_W-1:0] crc_update(logic [BYTE_W-1:0] crc, logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] v;
      v = crc ^ b;
      for (int i = 0; i < BYTE_W; i++) v = v[BYTE_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
      return v;
    endfunction

    function void note_request(logic [BYTE_W-1:0] b, logic start);
      phase_t      ph;
      int unsigned grp;
      sfd_result_t r;
      if (start && byte_pos != 0 && byte_pos < FRAME_LEN) frames_abandoned++;
      if (start || byte_pos >= FRAME_LEN) restart();
      ph  = phase_t'(byte_pos % GROUP_LEN);
      grp = byte_pos / GROUP_LEN;
      if (ph == PH_CHECK) begin
        if (crc_acc != b) err_seen = 1'b1;
        crc_acc = CRC_INIT;
      end else begin
        crc_acc = crc_update(crc_acc, b);
        if (grp < CO2_END) co2_word = {co2_word[WORD_W-BYTE_W-1:0], b};
        else if (grp < TEMP_END) temp_word = {temp_word[WORD_W-BYTE_W-1:0], b};
        else hum_word = {hum_word[WORD_W-BYTE_W-1:0], b};
      end
      if (byte_pos == FRAME_LEN - 1) begin
        r = '{co2_raw: co2_word, temperature_raw: temp_word, humidity_raw: hum_word,
              crc_error: err_seen};
        expected_frames.push_back(r);
        if (err_seen) frames_corrupt++;
        restart();
      end else begin
        byte_pos = byte_pos + 1'b1;
      end
    endfunction

    function void flag(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH %0s: expected %h, got %h", what, want, got);
    endfunction

    function void check_result(sfd_result_t got);
      sfd_result_t want;
      if (expected_frames.size() == 0) begin
        flag("result with no frame pending", '0, got.co2_raw);
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        if (got.co2_raw != want.co2_raw) flag("co2_raw", want.co2_raw, got.co2_raw);
        if (got.temperature_raw != want.temperature_raw)
          flag("temperature_raw", want.temperature_raw, got.temperature_raw);
        if (got.humidity_raw != want.humidity_raw)
          flag("humidity_raw", want.humidity_raw, got.humidity_raw);
        if (got.crc_error != want.crc_error)
          flag("crc_error", WORD_W'(want.crc_error), WORD_W'(got.crc_error));
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_frame_start = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_co2_raw;
  logic [WORD_W-1:0] out_temperature_raw;
  logic [WORD_W-1:0] out_humidity_raw;
  logic              out_crc_error;

  frame_predictor frames = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          phase_idx = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        aligned = 1'b1;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  sensor_frame_crc8_deframer_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_frame_start      (in_frame_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_co2_raw         (out_co2_raw),
    .out_temperature_raw (out_temperature_raw),
    .out_humidity_raw    (out_humidity_raw),
    .out_crc_error       (out_crc_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        frames.check_result({out_co2_raw, out_temperature_raw, out_humidity_raw, out_crc_error});
      if (phase_idx == PRESSURE_PHASE && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_frame_start <= start;
    do @(posedge clk); while (!in_ready);
    frames.note_request(b, start);
    items_sent++;
  endtask

  task automatic offer_frame(input logic [95:0] payload, input int bad_group,
                             input logic lead_start, input int len);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] b;
    int                k;
    crc = CRC_INIT;
    k   = 0;
    for (int pos = 0; pos < len; pos++) begin
      if (pos % GROUP_LEN == PH_CHECK) begin
        b = crc;
        if (pos / GROUP_LEN == bad_group) b = b ^ BYTE_W'(1 << $urandom_range(7));
        crc = CRC_INIT;
      end else begin
        b   = payload[95 - 8 * k -: 8];
        k   = k + 1;
        crc = frames.crc_update(crc, b);
      end
      offer_byte(b, (pos == 0) ? lead_start : 1'b0);
    end
  endtask

  task automatic offer_random_frame();
    logic [95:0] payload;
    int          kind;
    int          bad_group;
    int          len;
    kind      = $urandom_range(99);
    payload   = {$urandom, $urandom, $urandom};
    bad_group = ($urandom_range(99) < 25) ? int'($urandom_range(5)) : -1;
    len       = FRAME_LEN;
    if (kind < 8) payload = '0;
    else if (kind < 16) payload = '1;
    if (kind >= 95) begin
      repeat ($urandom_range(1, 5)) offer_byte(BYTE_W'($urandom), 1'($urandom));
      aligned = 1'b0;
    end else begin
      if (kind >= 85) len = $urandom_range(1, FRAME_LEN - 1);
      offer_frame(payload, bad_group, aligned ? 1'($urandom) : ($urandom_range(9) != 0), len);
      aligned = (len == FRAME_LEN);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // A short frame dropped by a new start, then all-ones data with a bad final check byte.
    offer_frame('0, -1, 1'b1, 4);
    offer_frame('1, 5, 1'b1, FRAME_LEN);

    for (int p = 0; p < PHASES; p++) begin
      phase_idx      <= p;
      recv_stall_pct <= RECV_STALL[p];
      send_idle_pct   = SEND_IDLE[p];
      while (items_sent < 22 + (p + 1) * PHASE_ITEMS) offer_random_frame();
    end
    in_valid <= 1'b0;

    while (frames.expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (frames.expected_frames.size() != 0)
      frames.flag("frames left unchecked", frames.expected_frames.size(), '0);
    $display("Sent %0d bytes over %0d idle and stall settings, one with a long output hold.",
             items_sent, PHASES);
    $display("Checked %0d frames: %0d with a failed check, %0d abandoned by a new start.",
             frames.frames_checked, frames.frames_corrupt, frames.frames_abandoned);
    if (frames.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total", frames.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/sfd_pkg.sv
src/sfd_in_reg.sv
src/sfd_frame_unit.sv
src/sensor_frame_crc8_deframer_core.sv
src/sfd_checker.sv
tb/sv/sensor_frame_crc8_deframer_core_tb.sv
